// ===== src/tun_pkg.sv =====
// Package: widths, payload types and constants of the triangle unit normal block.
`timescale 1ns / 1ps
package tun_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 14;
  localparam int OUT_WIDTH   = 16;

  localparam int EDGE_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W;
  localparam int MAG_W   = 2 * COORD_WIDTH + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int DIF_W   = SUM_W + 2 * FRAC_BITS + 3;
  localparam int QBITS   = FRAC_BITS + 1;
  localparam int NFRONT  = 6;
  localparam int NSTG    = NFRONT + QBITS + 1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;
    logic signed [COORD_WIDTH-1:0] third_x;
    logic signed [COORD_WIDTH-1:0] third_y;
    logic signed [COORD_WIDTH-1:0] third_z;
  } tun_in_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] normal_i;
    logic signed [OUT_WIDTH-1:0] normal_j;
    logic signed [OUT_WIDTH-1:0] normal_k;
    logic                        degenerate;
  } tun_out_t;

endpackage

// ===== src/triangle_unit_normal.sv =====
// Top level: pipelined unit face normal of one triangle in fixed point.
// Stages: six front stages (edges, products, cross, magnitude, squares, sum),
//   one stage per quotient bit of the root-divide, one output register.
// Throughput: one beat per cycle; a stall on the output freezes the whole pipe.
// Reset: synchronous active-low rst_n clears all stage valid bits; data needs none.
`timescale 1ns / 1ps
module triangle_unit_normal
  import tun_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tun_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tun_out_t out_data
);

  // One valid bit per stage; all stages move together when en is high.
  logic [NSTG-1:0] v_r;
  logic            en;

  assign en       = !v_r[NSTG-1] || !out_stall;
  assign in_stall = !en;
  assign out_valid = v_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_valid};
    end
  end

  // Stage 0: edge vectors a = second - first, b = third - first.
  // Index 0..2 = ax, ay, az; 3..5 = bx, by, bz.
  logic signed [EDGE_W-1:0] e_r [6];

  always_ff @(posedge clk) begin
    if (en) begin
      e_r[0] <= EDGE_W'(in_data.second_x) - EDGE_W'(in_data.first_x);
      e_r[1] <= EDGE_W'(in_data.second_y) - EDGE_W'(in_data.first_y);
      e_r[2] <= EDGE_W'(in_data.second_z) - EDGE_W'(in_data.first_z);
      e_r[3] <= EDGE_W'(in_data.third_x) - EDGE_W'(in_data.first_x);
      e_r[4] <= EDGE_W'(in_data.third_y) - EDGE_W'(in_data.first_y);
      e_r[5] <= EDGE_W'(in_data.third_z) - EDGE_W'(in_data.first_z);
    end
  end

  // Stage 1: the six partial products of the cross product.
  logic signed [PROD_W-1:0] p_r [6];

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= PROD_W'(e_r[1]) * PROD_W'(e_r[5]);
      p_r[1] <= PROD_W'(e_r[2]) * PROD_W'(e_r[4]);
      p_r[2] <= PROD_W'(e_r[2]) * PROD_W'(e_r[3]);
      p_r[3] <= PROD_W'(e_r[0]) * PROD_W'(e_r[5]);
      p_r[4] <= PROD_W'(e_r[0]) * PROD_W'(e_r[4]);
      p_r[5] <= PROD_W'(e_r[1]) * PROD_W'(e_r[3]);
    end
  end

  // Stage 2: exact cross product C = a x b.
  logic signed [CROSS_W-1:0] c_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      c_r[0] <= p_r[0] - p_r[1];
      c_r[1] <= p_r[2] - p_r[3];
      c_r[2] <= p_r[4] - p_r[5];
    end
  end

  // Stage 3: magnitude, sign, degenerate flag.
  logic [MAG_W-1:0] m_r [3];
  logic [2:0]       sg3_r;
  logic             dg3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        m_r[l]   <= c_r[l][CROSS_W-1] ? MAG_W'(-c_r[l]) : MAG_W'(c_r[l]);
        sg3_r[l] <= c_r[l][CROSS_W-1];
      end
      dg3_r <= (c_r[0] == '0) && (c_r[1] == '0) && (c_r[2] == '0);
    end
  end

  // Stage 4: squares of the magnitudes.
  logic [SQ_W-1:0] sq_r [3];
  logic [2:0]      sg4_r;
  logic            dg4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        sq_r[l] <= SQ_W'(m_r[l]) * SQ_W'(m_r[l]);
      end
      sg4_r <= sg3_r;
      dg4_r <= dg3_r;
    end
  end

  // Stage 5: S = |C|^2 and per-lane target R = c^2 * 2^(2F).
  logic [SUM_W-1:0] s5_r;
  logic [DIF_W-1:0] r5_r [3];
  logic [2:0]       sg5_r;
  logic             dg5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      for (int l = 0; l < 3; l++) begin
        r5_r[l] <= DIF_W'(sq_r[l]) << (2 * FRAC_BITS);
      end
      sg5_r <= sg4_r;
      dg5_r <= dg4_r;
    end
  end

  // Root-divide: largest q with q^2*S <= R, one quotient bit per stage.
  // Tracks D = R - q^2*S and Q = q*S; trying bit b costs
  // (Q << (b+1)) + (S << 2b), so no multiplier is needed.
  logic [DIF_W-1:0] it_d_r [QBITS][3];
  logic [DIF_W-1:0] it_q_r [QBITS][3];
  logic [QBITS-1:0] it_n_r [QBITS][3];
  logic [SUM_W-1:0] it_s_r [QBITS];
  logic [2:0]       it_sg_r [QBITS];
  logic             it_dg_r [QBITS];

  for (genvar j = 0; j < QBITS; j++) begin : g_bit
    localparam int B = FRAC_BITS - j;

    logic [DIF_W-1:0] src_d [3];
    logic [DIF_W-1:0] src_q [3];
    logic [QBITS-1:0] src_n [3];
    logic [SUM_W-1:0] src_s;
    logic [2:0]       src_sg;
    logic             src_dg;
    logic [DIF_W-1:0] term [3];
    logic [DIF_W-1:0] s_w;

    if (j == 0) begin : g_src
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          src_d[l] = r5_r[l];
          src_q[l] = '0;
          src_n[l] = '0;
        end
        src_s  = s5_r;
        src_sg = sg5_r;
        src_dg = dg5_r;
      end
    end else begin : g_src
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          src_d[l] = it_d_r[j-1][l];
          src_q[l] = it_q_r[j-1][l];
          src_n[l] = it_n_r[j-1][l];
        end
        src_s  = it_s_r[j-1];
        src_sg = it_sg_r[j-1];
        src_dg = it_dg_r[j-1];
      end
    end

    assign s_w = DIF_W'(src_s);

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        term[l] = (src_q[l] << (B + 1)) + (s_w << (2 * B));
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          if (term[l] <= src_d[l]) begin
            it_d_r[j][l] <= src_d[l] - term[l];
            it_q_r[j][l] <= src_q[l] + (s_w << B);
            it_n_r[j][l] <= src_n[l] | (QBITS'(1) << B);
          end else begin
            it_d_r[j][l] <= src_d[l];
            it_q_r[j][l] <= src_q[l];
            it_n_r[j][l] <= src_n[l];
          end
        end
        it_s_r[j]  <= src_s;
        it_sg_r[j] <= src_sg;
        it_dg_r[j] <= src_dg;
      end
    end
  end

  // Output register: apply sign, extend to OUT_WIDTH, force zero when degenerate.
  tun_out_t out_r;
  logic [OUT_WIDTH-1:0] mag_o [3];
  logic [OUT_WIDTH-1:0] cmp_o [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag_o[l] = OUT_WIDTH'(it_n_r[QBITS-1][l]);
      if (it_dg_r[QBITS-1]) begin
        cmp_o[l] = '0;
      end else if (it_sg_r[QBITS-1][l]) begin
        cmp_o[l] = -mag_o[l];
      end else begin
        cmp_o[l] = mag_o[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.normal_i   <= cmp_o[0];
      out_r.normal_j   <= cmp_o[1];
      out_r.normal_k   <= cmp_o[2];
      out_r.degenerate <= it_dg_r[QBITS-1];
    end
  end

  assign out_data = out_r;

  // A degenerate beat carries a zero normal.
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.normal_i == '0 && out_data.normal_j == '0 && out_data.normal_k == '0)
    else $error("degenerate beat with nonzero normal");

  // Input is held off only while a finished beat is stuck at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // A beat in the last root stage reaches the output on an advancing edge.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NSTG-2] && en |=> out_valid)
    else $error("beat lost between root stage and output");

  // A stalled output beat keeps its pipeline slot and data.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_r))
    else $error("stalled output beat changed");

endmodule
